[rtl/core/ffea_pkg.sv]
package ffea_pkg;

  localparam int unsigned MAX_EXTENTS = 64;
  localparam int unsigned BLK_W       = 32;

  localparam logic [BLK_W-1:0] TOTAL_RESET = 32'd100000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOSPACE = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_RANGE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ASCAN,
    S_FSCAN,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage

[rtl/core/ffea_req_if.sv]
interface ffea_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] start_block;
  logic [31:0] block_count;

  modport source (output valid, output kind, output start_block, output block_count,
                  input ready);
  modport sink (input valid, input kind, input start_block, input block_count,
                output ready);
endinterface

[rtl/core/ffea_rsp_if.sv]
interface ffea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink (input valid, input block_address, input status, output ready);
endinterface

[rtl/core/ffea_ram.sv]
module ffea_ram #(
  parameter int unsigned Width = 2 * ffea_pkg::BLK_W,
  parameter int unsigned Depth = ffea_pkg::MAX_EXTENTS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/first_fit_extent_allocator.sv]
// First-fit allocator over a table of free extents kept in one on-chip RAM, sorted by start
// address. The block takes one transaction at a time and is not ready until its result has
// been handed to the output register, which may still hold the previous result. An allocate
// streams the table through the RAM read port one entry per cycle until the first extent that
// fits, and a free until the first extent that starts above the freed run; a removal or sorted
// insert then moves the following entries by one place, again one per cycle. Some requests
// are answered without reading the table; the others scan it and may then shift part of it.
// While the output register waits for the receiver, the block holds its result and is not
// ready. After reset or a write of cfg_wdata_i as the total block count the block writes the
// first table entry before it becomes ready.
module first_fit_extent_allocator #(
  parameter int unsigned MaxExtents = ffea_pkg::MAX_EXTENTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffea_pkg::BLK_W-1:0]  cfg_wdata_i,
  ffea_req_if.sink                    req_i,
  ffea_rsp_if.source                  rsp_o
);

  import ffea_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxExtents);
  localparam int unsigned CntW = $clog2(MaxExtents + 1);
  localparam int unsigned EntW = 2 * BLK_W;

  state_e            state_q, state_d;
  logic [BLK_W-1:0]  total_q, total_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [BLK_W-1:0]  s_q, s_d;
  logic [BLK_W-1:0]  n_q, n_d;
  logic [BLK_W-1:0]  end_q, end_d;
  logic [IdxW-1:0]   rd_q, rd_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [IdxW-1:0]   di_q, di_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic              all_q, all_d;
  logic              dv_q, dv_d;
  logic              dec_q, dec_d;
  logic              ins_q, ins_d;
  logic [BLK_W-1:0]  res_addr_q, res_addr_d;
  status_e           res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  logic [BLK_W-1:0]  out_addr_q, out_addr_d;
  status_e           out_st_q, out_st_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntW-1:0]   ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [EntW-1:0]   ram_rdata;
  logic [BLK_W-1:0]  rd_start;
  logic [BLK_W-1:0]  rd_len;
  logic [BLK_W:0]    sum33;
  logic [BLK_W:0]    diff33;
  logic              range_bad;
  logic              issue;
  logic [IdxW-1:0]   cnt_last;

  ffea_ram #(
    .Width (EntW),
    .Depth (MaxExtents)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_start  = ram_rdata[EntW-1:BLK_W];
  assign rd_len    = ram_rdata[BLK_W-1:0];
  assign sum33     = {1'b0, req_i.start_block} + {1'b0, req_i.block_count};
  assign range_bad = (req_i.start_block >= total_q) || (sum33 > {1'b0, total_q});
  assign diff33    = {1'b0, rd_len} - {1'b0, n_q};
  assign cnt_last  = IdxW'(cnt_q - 1'b1);

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.status        = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      total_q     <= TOTAL_RESET;
      cnt_q       <= CntW'(1);
      all_q       <= 1'b1;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      all_q       <= all_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    n_q        <= n_d;
    end_q      <= end_d;
    rd_q       <= rd_d;
    last_q     <= last_d;
    di_q       <= di_d;
    pos_q      <= pos_d;
    dec_q      <= dec_d;
    ins_q      <= ins_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    n_d         = n_q;
    end_d       = end_q;
    rd_d        = rd_q;
    last_d      = last_q;
    di_d        = di_q;
    pos_d       = pos_q;
    all_d       = all_q;
    dv_d        = 1'b0;
    dec_d       = dec_q;
    ins_d       = ins_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = rd_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    issue = (state_q inside {S_ASCAN, S_FSCAN, S_SHIFT}) && !all_q;
    if (issue) begin
      dv_d = 1'b1;
      di_d = rd_q;
      rd_d = dec_q ? rd_q - 1'b1 : rd_q + 1'b1;
      if (rd_q == last_q) begin
        all_d = 1'b1;
      end
    end

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {{BLK_W{1'b0}}, total_q};
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid) begin
          s_d        = req_i.start_block;
          n_d        = req_i.block_count;
          end_d      = sum33[BLK_W-1:0];
          res_addr_d = '0;
          res_st_d   = STATUS_OK;
          rd_d       = '0;
          last_d     = cnt_last;
          all_d      = 1'b0;
          dec_d      = 1'b0;
          if (req_i.block_count == '0) begin
            state_d = S_RESP;
          end else if (req_i.kind == KIND_ALLOC) begin
            if (cnt_q == '0) begin
              res_st_d = STATUS_NOSPACE;
              state_d  = S_RESP;
            end else begin
              state_d = S_ASCAN;
            end
          end else if (range_bad) begin
            res_st_d = STATUS_RANGE;
            state_d  = S_RESP;
          end else if (cnt_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {req_i.start_block, req_i.block_count};
            cnt_d     = CntW'(1);
            state_d   = S_RESP;
          end else begin
            state_d = S_FSCAN;
          end
        end
      end
      S_ASCAN: begin
        if (dv_q) begin
          if (!diff33[BLK_W]) begin
            res_addr_d = rd_start;
            res_st_d   = STATUS_OK;
            dv_d       = 1'b0;
            if (diff33[BLK_W-1:0] != '0) begin
              ram_we    = 1'b1;
              ram_waddr = di_q;
              ram_wdata = {rd_start + n_q, diff33[BLK_W-1:0]};
              state_d   = S_RESP;
            end else if (di_q == cnt_last) begin
              cnt_d   = cnt_q - 1'b1;
              state_d = S_RESP;
            end else begin
              rd_d    = di_q + 1'b1;
              last_d  = cnt_last;
              all_d   = 1'b0;
              dec_d   = 1'b0;
              ins_d   = 1'b0;
              state_d = S_SHIFT;
            end
          end else if (di_q == last_q) begin
            res_st_d = STATUS_NOSPACE;
            dv_d     = 1'b0;
            state_d  = S_RESP;
          end
        end
      end
      S_FSCAN: begin
        if (dv_q) begin
          if (rd_start > s_q) begin
            dv_d = 1'b0;
            if (end_q == rd_start) begin
              ram_we    = 1'b1;
              ram_waddr = di_q;
              ram_wdata = {s_q, rd_len + n_q};
              state_d   = S_RESP;
            end else if (cnt_q == CntW'(MaxExtents)) begin
              res_st_d = STATUS_FULL;
              state_d  = S_RESP;
            end else begin
              rd_d    = cnt_last;
              last_d  = di_q;
              pos_d   = di_q;
              all_d   = 1'b0;
              dec_d   = 1'b1;
              ins_d   = 1'b1;
              state_d = S_SHIFT;
            end
          end else if (di_q == last_q) begin
            dv_d = 1'b0;
            if (cnt_q == CntW'(MaxExtents)) begin
              res_st_d = STATUS_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[IdxW-1:0];
              ram_wdata = {s_q, n_q};
              cnt_d     = cnt_q + 1'b1;
            end
            state_d = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = dec_q ? di_q + 1'b1 : di_q - 1'b1;
          ram_wdata = ram_rdata;
        end else if (all_q) begin
          if (ins_q) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q;
            ram_wdata = {s_q, n_q};
            cnt_d     = cnt_q + 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
      cnt_d   = CntW'(cfg_wdata_i != '0);
      dv_d    = 1'b0;
      state_d = S_INIT;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxExtents))
    else $error("extent count exceeds table depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("ready right after an accepted transaction");

  a_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ({1'b0, ram_waddr} <= (IdxW + 1)'(cnt_q)))
    else $error("table write beyond the extent count");

  a_data_only_when_streaming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> (state_q == S_ASCAN || state_q == S_FSCAN || state_q == S_SHIFT))
    else $error("read data pending outside a scan or shift");

  a_result_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && !cfg_we_i && (!out_valid_q || rsp_o.ready) |=> out_valid_q)
    else $error("result not loaded into the output register");
`endif

endmodule

[test/ffea_checker.sv]
module ffea_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ffea_pkg::BLK_W-1:0] cfg_wdata_i,
  ffea_req_if                        req_i,
  ffea_rsp_if                        rsp_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                outstanding_o
);
  import ffea_pkg::*;

  typedef struct packed {
    logic [BLK_W-1:0] block_address;
    status_e          status;
  } answer_t;

  logic [BLK_W-1:0] space_total;
  logic [BLK_W-1:0] ext_base [MAX_EXTENTS];
  logic [BLK_W-1:0] ext_len  [MAX_EXTENTS];
  int               ext_used;
  answer_t          answer_q [$];
  int unsigned      mismatches = 0;
  int unsigned      waiting = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = waiting;

  function automatic void format_table(input logic [BLK_W-1:0] total);
    space_total = total;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      ext_base[i] = '0;
      ext_len[i]  = '0;
    end
    ext_len[0] = total;
    ext_used   = (total != 0) ? 1 : 0;
  endfunction

  function automatic answer_t carve(input logic [BLK_W-1:0] n);
    answer_t a;
    a.block_address = '0;
    a.status        = STATUS_OK;
    if (n == 0) return a;
    for (int i = 0; i < ext_used; i++) begin
      if (ext_len[i] >= n) begin
        a.block_address = ext_base[i];
        if (n < ext_len[i]) begin
          ext_base[i] = ext_base[i] + n;
          ext_len[i]  = ext_len[i] - n;
        end else begin
          for (int j = i; j + 1 < ext_used; j++) begin
            ext_base[j] = ext_base[j+1];
            ext_len[j]  = ext_len[j+1];
          end
          ext_used--;
        end
        return a;
      end
    end
    a.status = STATUS_NOSPACE;
    return a;
  endfunction

  function automatic answer_t release_run(input logic [BLK_W-1:0] s, input logic [BLK_W-1:0] n);
    answer_t      a;
    logic [BLK_W:0] stop;
    int           pos;
    a.block_address = '0;
    a.status        = STATUS_OK;
    stop = {1'b0, s} + {1'b0, n};
    if (n == 0) return a;
    if (s >= space_total || stop > {1'b0, space_total}) begin
      a.status = STATUS_RANGE;
      return a;
    end
    pos = 0;
    while (pos < ext_used && ext_base[pos] <= s) pos++;
    if (pos < ext_used && stop == {1'b0, ext_base[pos]}) begin
      ext_base[pos] = s;
      ext_len[pos]  = ext_len[pos] + n;
      return a;
    end
    if (ext_used >= MAX_EXTENTS) begin
      a.status = STATUS_FULL;
      return a;
    end
    for (int i = ext_used; i > pos; i--) begin
      ext_base[i] = ext_base[i-1];
      ext_len[i]  = ext_len[i-1];
    end
    ext_base[pos] = s;
    ext_len[pos]  = n;
    ext_used++;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_table(TOTAL_RESET);
      answer_q.delete();
      waiting <= 0;
    end else begin : watch
      answer_t want;
      if (cfg_we_i) format_table(cfg_wdata_i);
      if (req_i.valid && req_i.ready) begin
        if (req_i.kind == KIND_ALLOC) begin
          answer_q.push_back(carve(req_i.block_count));
        end else begin
          answer_q.push_back(release_run(req_i.start_block, req_i.block_count));
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (answer_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("mismatch: unexpected result block_address %h status %0d",
                     rsp_i.block_address, rsp_i.status);
          end
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (rsp_i.block_address !== want.block_address || rsp_i.status !== want.status) begin
            if (mismatches < 10) begin
              $display("mismatch: block_address expected %h got %h, status expected %0d got %0d",
                       want.block_address, rsp_i.block_address, want.status, rsp_i.status);
            end
            mismatches++;
          end
        end
      end
      waiting <= answer_q.size();
    end
  end

endmodule

[test/tb_first_fit_extent_allocator.sv]
module tb_first_fit_extent_allocator;
  import ffea_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_EXTENTS + 16;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  typedef struct {
    logic [BLK_W-1:0] base;
    logic [BLK_W-1:0] len;
  } run_t;

  typedef struct {
    logic             kind;
    logic [BLK_W-1:0] count;
  } asked_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [BLK_W-1:0] cfg_wdata;
  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      quiet_cycles = 0;
  idle_e            idle_mode = IDLE_NONE;
  logic             growing = 1'b1;
  run_t             held_q [$];
  asked_t           asked_q [$];

  ffea_req_if req_if();
  ffea_rsp_if rsp_if();

  always #5 clk = ~clk;

  first_fit_extent_allocator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  ffea_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always @(posedge clk) begin : rx_side
    int unsigned roll;
    roll = $urandom_range(99);
    rsp_if.ready <= !((idle_mode == IDLE_RECEIVER && roll < 68) ||
                      (idle_mode == IDLE_BOTH && roll < 7));
  end

  // Allocated runs are learned from the results so that most frees are well formed.
  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready && asked_q.size() != 0) begin : note
      asked_t a;
      run_t   r;
      a = asked_q.pop_front();
      if (a.kind == KIND_ALLOC && rsp_if.status == STATUS_OK && a.count != 0) begin
        r.base = rsp_if.block_address;
        r.len  = a.count;
        held_q.push_back(r);
      end
      if (a.kind == KIND_ALLOC && rsp_if.status == STATUS_NOSPACE) growing = 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_request(input logic kind, input logic [BLK_W-1:0] s,
                             input logic [BLK_W-1:0] n);
    asked_t a;
    while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 68) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 7)) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.start_block <= s;
    req_if.block_count <= n;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    a.kind  = kind;
    a.count = n;
    asked_q.push_back(a);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_item(input logic [BLK_W-1:0] total);
    int unsigned      roll;
    int unsigned      pick;
    logic [BLK_W-1:0] s;
    logic [BLK_W-1:0] n;
    logic [BLK_W-1:0] cap;
    run_t             r;
    cap = (total / 100 > 0) ? total / 100 : 1;
    if (!growing && (held_q.size() < 4 || $urandom_range(99) == 0)) growing = 1'b1;
    roll = $urandom_range(99);
    if (growing ? roll < 75 : roll < 15) begin
      s    = $urandom;
      roll = $urandom_range(99);
      if (roll < 4) n = '0;
      else if (roll < 10 && !growing) n = $urandom;
      else n = $urandom_range(cap, 1);
      put_request(KIND_ALLOC, s, n);
    end else if (held_q.size() != 0 && $urandom_range(99) < 80) begin
      pick = $urandom_range(held_q.size() - 1);
      r    = held_q[pick];
      if (r.len > 1 && $urandom_range(99) < 30) begin
        n = $urandom_range(r.len - 1, 1);
        held_q[pick].base = r.base + n;
        held_q[pick].len  = r.len - n;
      end else begin
        n = r.len;
        held_q.delete(pick);
      end
      put_request(KIND_FREE, r.base, n);
    end else begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        s = $urandom_range(total - 1);
        n = $urandom_range(cap, 1);
      end else if (roll < 65) begin
        s = $urandom;
        n = $urandom;
      end else if (roll < 75) begin
        s = $urandom;
        n = '0;
      end else if (roll < 88) begin
        s = $urandom_range(total - 1);
        n = total - s + $urandom_range(1);
      end else begin
        s = 32'hFFFF_FFFF - $urandom_range(15);
        n = $urandom_range(32, 1);
      end
      put_request(KIND_FREE, s, n);
    end
  endtask

  task automatic run_phase(input logic [BLK_W-1:0] total, input int unsigned items,
                           input idle_e mode);
    drain();
    held_q.delete();
    growing = 1'b1;
    cfg_we    <= 1'b1;
    cfg_wdata <= total;
    @(posedge clk);
    cfg_we    <= 1'b0;
    idle_mode = mode;
    repeat (items) random_item(total);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_if.valid       = 1'b0;
    req_if.kind        = KIND_ALLOC;
    req_if.start_block = '0;
    req_if.block_count = '0;
    rsp_if.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    put_request(KIND_ALLOC, 32'h0, 32'd0);
    put_request(KIND_FREE, 32'h1234_5678, 32'd0);
    put_request(KIND_ALLOC, 32'h0, 32'd1);
    put_request(KIND_ALLOC, 32'h0, 32'd99999);
    put_request(KIND_ALLOC, 32'h0, 32'd1);
    put_request(KIND_FREE, 32'd100000, 32'd1);
    put_request(KIND_FREE, 32'd99999, 32'd2);
    put_request(KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_request(KIND_FREE, 32'd50, 32'd10);
    put_request(KIND_FREE, 32'd40, 32'd10);
    put_request(KIND_FREE, 32'd0, 32'd1);
    put_request(KIND_FREE, 32'd99999, 32'd1);
    put_request(KIND_FREE, 32'd60, 32'd5);
    put_request(KIND_ALLOC, 32'h0, 32'd25);
    put_request(KIND_ALLOC, 32'h0, 32'd20);
    put_request(KIND_ALLOC, 32'h0, 32'd3);
    put_request(KIND_ALLOC, 32'h0, 32'hFFFF_FFFF);
    put_request(KIND_FREE, 32'd1, 32'd39);
    put_request(KIND_FREE, 32'd0, 32'd5);
    put_request(KIND_ALLOC, 32'hFFFF_FFFF, 32'd1);
    put_request(KIND_FREE, 32'd0, 32'd100000);

    idle_mode = IDLE_NONE;
    repeat (120) random_item(TOTAL_RESET);
    run_phase(32'd200, 300, IDLE_SENDER);
    run_phase(32'd1, 50, IDLE_RECEIVER);
    run_phase(32'hFFFF_FFFF, 150, IDLE_BOTH);
    run_phase(32'd300, 220, IDLE_NONE);
    run_phase($urandom_range(5000, 64), 120, IDLE_RECEIVER);
    run_phase(32'd150, 100, IDLE_BOTH);
    run_phase($urandom_range(32'hFFFF_FFFF, 1), 80, IDLE_SENDER);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ffea_pkg.sv
rtl/core/ffea_req_if.sv
rtl/core/ffea_rsp_if.sv
rtl/core/ffea_ram.sv
rtl/core/first_fit_extent_allocator.sv
test/ffea_checker.sv
test/tb_first_fit_extent_allocator.sv
